/* rtl/msmac_pkg.sv */
`default_nettype none
package msmac_pkg;

    typedef struct packed {
        logic [23:0] adc_code;
        logic [7:0]  elapsed_ticks;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] value_q16;
        logic [2:0]         value_channel;
        logic               value_valid;
        logic               stop_convert;
        logic [1:0]         phase;
        logic [2:0]         mux_address;
    } out_item_t;

    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_DEPTH  = 2'd2;
    localparam logic [1:0] CFG_SETTLE = 2'd3;

    localparam logic [1:0] PH_SELECT = 2'd0;
    localparam logic [1:0] PH_SETTLE = 2'd1;
    localparam logic [1:0] PH_SAMPLE = 2'd2;
    localparam logic [1:0] PH_STOP   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SUM,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic start;     // item accepted: latch inputs, do phase step
        logic wr;        // write history, start sum
        logic sum_step;  // add one entry
        logic div_step;  // one quotient bit
        logic mul_step;  // gain multiply and final add
        logic out_load;  // load output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sample;
        logic sum_done;
        logic div_done;
    } dp_stat_t;

endpackage
`default_nettype wire

/* rtl/msmac_ctrl.sv */
`default_nettype none
module msmac_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              m_ready,
    output logic                   m_valid,
    output msmac_pkg::dp_cmd_t     cmd,
    input  wire msmac_pkg::dp_stat_t stat
);
    msmac_pkg::ctrl_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    // state and output valid registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= msmac_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            msmac_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = msmac_pkg::ST_WRITE;
                end
            end
            msmac_pkg::ST_WRITE: begin
                if (stat.is_sample) begin
                    cmd.wr     = 1'b1;
                    state_next = msmac_pkg::ST_SUM;
                end else begin
                    state_next = msmac_pkg::ST_OUT;
                end
            end
            msmac_pkg::ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done) state_next = msmac_pkg::ST_DIV;
            end
            msmac_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) state_next = msmac_pkg::ST_MUL;
            end
            msmac_pkg::ST_MUL: begin
                cmd.mul_step = 1'b1;
                state_next   = msmac_pkg::ST_OUT;
            end
            msmac_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = msmac_pkg::ST_IDLE;
                end
            end
            default: state_next = msmac_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/msmac_dp.sv */
`default_nettype none
module msmac_dp #(
    parameter int CHANNELS      = 8,
    parameter int HISTORY_DEPTH = 16,
    parameter int CODE_BITS     = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire msmac_pkg::in_item_t  s_data,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data,
    input  wire msmac_pkg::dp_cmd_t   cmd,
    output msmac_pkg::dp_stat_t       stat,
    output msmac_pkg::out_item_t      m_data
);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SL_W   = $clog2(HISTORY_DEPTH);
    localparam int FC_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = CODE_BITS + 5;
    localparam int NUM_W  = SUM_W + 16;
    localparam int MEM_D  = CHANNELS * (2 ** SL_W);
    localparam int ADDR_W = CH_W + SL_W;
    localparam logic [SL_W-1:0] LAST_SLOT = SL_W'(HISTORY_DEPTH - 1);
    localparam logic [CH_W-1:0] LAST_CH   = CH_W'(CHANNELS - 1);

    // configuration registers
    logic signed [31:0] gain_reg, offset_reg;
    logic [4:0]         depth_reg;
    logic [15:0]        settle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg   <= 32'sd65536;
            offset_reg <= '0;
            depth_reg  <= 5'd10;
            settle_reg <= 16'd200;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                msmac_pkg::CFG_GAIN:   gain_reg   <= cfg_data;
                msmac_pkg::CFG_OFFSET: offset_reg <= cfg_data;
                msmac_pkg::CFG_DEPTH:  depth_reg  <= cfg_data[4:0];
                msmac_pkg::CFG_SETTLE: settle_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // scan sequencer state
    logic [1:0]      phase_reg, exec_reg;
    logic [CH_W-1:0] chan_reg;
    logic [15:0]     settle_el_reg;
    logic [2:0]      mux_reg;
    logic [CODE_BITS-1:0] code_reg;
    logic [SL_W-1:0] wslot_reg [CHANNELS];
    logic [FC_W-1:0] fill_reg  [CHANNELS];
    logic [16:0]     settle_acc;

    assign settle_acc = {1'b0, settle_el_reg} + 17'(s_data.elapsed_ticks);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= msmac_pkg::PH_SELECT;
            exec_reg      <= msmac_pkg::PH_SELECT;
            chan_reg      <= '0;
            settle_el_reg <= '0;
            mux_reg       <= '0;
        end else if (cmd.start) begin
            exec_reg <= phase_reg;
            code_reg <= s_data.adc_code[CODE_BITS-1:0];
            case (phase_reg)
                msmac_pkg::PH_SELECT: begin
                    mux_reg       <= 3'(chan_reg);
                    settle_el_reg <= '0;
                    phase_reg     <= msmac_pkg::PH_SETTLE;
                end
                msmac_pkg::PH_SETTLE: begin
                    settle_el_reg <= settle_acc[16] ? 16'hFFFF : settle_acc[15:0];
                    if ((settle_acc[16] ? 16'hFFFF : settle_acc[15:0]) > settle_reg)
                        phase_reg <= msmac_pkg::PH_SAMPLE;
                end
                msmac_pkg::PH_SAMPLE: phase_reg <= msmac_pkg::PH_STOP;
                default: begin
                    chan_reg  <= (chan_reg == LAST_CH) ? '0 : chan_reg + 1'b1;
                    phase_reg <= msmac_pkg::PH_SELECT;
                end
            endcase
        end
    end

    assign stat.is_sample = (exec_reg == msmac_pkg::PH_SAMPLE);

    // per-channel ring pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                wslot_reg[i] <= '0;
                fill_reg[i]  <= '0;
            end
        end else if (cmd.wr) begin
            wslot_reg[chan_reg] <= (wslot_reg[chan_reg] == LAST_SLOT) ? '0
                                   : wslot_reg[chan_reg] + 1'b1;
            if (fill_reg[chan_reg] < FC_W'(HISTORY_DEPTH))
                fill_reg[chan_reg] <= fill_reg[chan_reg] + 1'b1;
        end
    end

    // history memory
    logic [CODE_BITS-1:0] mem [MEM_D];
    logic [CODE_BITS-1:0] rd_reg;
    logic [ADDR_W-1:0]    rd_addr;
    logic [SL_W-1:0]      rslot_reg;
    logic [4:0]           n_reg, cnt_reg;
    logic                 rd_ok_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [4:0]           dep_eff;
    logic [FC_W:0]        fill_new;

    assign rd_addr = {chan_reg, rslot_reg};

    always_ff @(posedge aclk) begin
        if (cmd.wr) mem[{chan_reg, wslot_reg[chan_reg]}] <= code_reg;
        rd_reg <= mem[rd_addr];
    end

    assign dep_eff  = (depth_reg == 5'd0) ? 5'd1 : depth_reg;
    assign fill_new = (fill_reg[chan_reg] < FC_W'(HISTORY_DEPTH))
                      ? (FC_W+1)'(fill_reg[chan_reg]) + 1'b1
                      : (FC_W+1)'(fill_reg[chan_reg]);

    // sum over newest entries: one read per cycle, read data registered
    always_ff @(posedge aclk) begin
        if (cmd.wr) begin
            rslot_reg <= wslot_reg[chan_reg];
            n_reg     <= (32'(dep_eff) < 32'(fill_new)) ? dep_eff : 5'(fill_new);
            cnt_reg   <= '0;
            rd_ok_reg <= 1'b0;
            sum_reg   <= '0;
        end else if (cmd.sum_step) begin
            if (rd_ok_reg) sum_reg <= sum_reg + SUM_W'(rd_reg);
            rd_ok_reg <= (cnt_reg < n_reg);
            cnt_reg   <= cnt_reg + 1'b1;
            rslot_reg <= (rslot_reg == '0) ? LAST_SLOT : rslot_reg - 1'b1;
        end
    end
    // entry written at cycle of wr is read back first; cnt counts issued reads
    assign stat.sum_done = cmd.sum_step && (cnt_reg == n_reg) && rd_ok_reg;

    // restoring divider, one quotient bit per cycle
    logic [NUM_W-1:0] quo_reg;
    logic [5:0]       rem_reg;
    logic [6:0]       bit_reg;
    logic [6:0]       rem_sh;
    logic             div_first;

    assign rem_sh = {rem_reg, quo_reg[NUM_W-1]};
    assign div_first = stat.sum_done;
    always_ff @(posedge aclk) begin
        if (div_first) begin
            quo_reg <= {sum_reg + SUM_W'(rd_reg), 16'h0};
            rem_reg <= '0;
            bit_reg <= '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= 7'(n_reg)) begin
                rem_reg <= 6'(rem_sh - 7'(n_reg));
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[5:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
            bit_reg <= bit_reg + 1'b1;
        end
    end
    assign stat.div_done = cmd.div_step && (bit_reg == 7'(NUM_W - 1));

    // gain multiply: integer part and fraction part, clamp, offset, saturate
    logic [NUM_W-1:0]   avg;
    logic signed [CODE_BITS+38:0] prod_hi;
    logic signed [49:0] prod_lo;
    logic signed [41:0] hi_cl;
    logic signed [43:0] total;
    logic signed [31:0] val_reg;

    assign avg     = quo_reg;
    assign prod_hi = gain_reg * $signed({1'b0, avg[NUM_W-1:16]});
    assign prod_lo = gain_reg * $signed({1'b0, avg[15:0]});
    assign hi_cl   = (prod_hi > (CODE_BITS+39)'(64'sd1 <<< 40)) ? 42'sd1 <<< 40 :
                     (prod_hi < -(CODE_BITS+39)'(64'sd1 <<< 40)) ? -(42'sd1 <<< 40) :
                     42'(prod_hi);
    assign total   = 44'(hi_cl) + 44'(prod_lo >>> 16) + 44'(offset_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_step) begin
            if (total > 44'sd2147483647) val_reg <= 32'h7FFFFFFF;
            else if (total < -44'sd2147483648) val_reg <= 32'h80000000;
            else val_reg <= total[31:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data.mux_address   <= mux_reg;
            m_data.phase         <= exec_reg;
            m_data.stop_convert  <= (exec_reg == msmac_pkg::PH_STOP);
            m_data.value_valid   <= stat.is_sample;
            m_data.value_channel <= stat.is_sample ? 3'(chan_reg) : 3'd0;
            m_data.value_q16     <= stat.is_sample ? val_reg : 32'sd0;
        end
    end
endmodule
`default_nettype wire

/* rtl/mux_scan_moving_average_calibrate.sv */
`default_nettype none
// select, settle and stop steps pass through the write and output states; sample steps
// also run the history sum over min(depth,fill) entries, one entry per cycle, the
// divider, one bit per cycle, and the gain multiply before the output state
// one item at a time; next item accepted once the result is in the output register
// reset (aresetn low, synchronous) clears scan state, ring pointers and config
module mux_scan_moving_average_calibrate #(
    parameter int CHANNELS      = 8,
    parameter int HISTORY_DEPTH = 16,
    parameter int CODE_BITS     = 24
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire msmac_pkg::in_item_t  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output msmac_pkg::out_item_t      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [31:0]          cfg_data
);
    msmac_pkg::dp_cmd_t  cmd;
    msmac_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    msmac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .cmd     (cmd),
        .stat    (stat)
    );

    msmac_dp #(
        .CHANNELS      (CHANNELS),
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CODE_BITS     (CODE_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );
endmodule
`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import msmac_pkg::*;

    localparam int N_CH = 8;
    localparam int HIST = 16;
    localparam int STALL_LIMIT = 4000;

    typedef enum bit {ROW_CFG, ROW_ITEM} row_kind_e;
    typedef struct {
        row_kind_e  kind;
        logic [1:0] idx;
        logic [31:0] data;
        bit         has_exp;
        out_item_t  exp;
    } row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    mux_scan_moving_average_calibrate dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // scan model state and register copies
    logic signed [31:0] gain_r, offset_r;
    logic [4:0]  depth_r;
    logic [15:0] settle_r;
    logic [1:0]  scan_ph;
    logic [2:0]  scan_ch;
    logic [15:0] settle_acc;
    logic [2:0]  mux_sel;
    logic [23:0] ring [N_CH][HIST];
    int          ring_wr [N_CH];
    int          ring_fill [N_CH];

    out_item_t   pending_results[$];
    int          errors = 0;
    bit          idle_on = 1;
    int          stall_left = 0;
    int          quiet_cycles = 0;

    // clock
    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    // calibrated moving average of one channel after storing a code
    function automatic logic signed [31:0] calibrated_average(int ch, logic [23:0] code);
        logic [63:0] sum, avg;
        longint prod, part, total;
        int n, slot, dep;
        ring[ch][ring_wr[ch]] = code;
        ring_wr[ch] = (ring_wr[ch] + 1) % HIST;
        if (ring_fill[ch] < HIST) ring_fill[ch]++;
        dep = (depth_r == 0) ? 1 : int'(depth_r);
        n = (dep < ring_fill[ch]) ? dep : ring_fill[ch];
        sum = 0;
        slot = ring_wr[ch];
        for (int i = 0; i < n; i++) begin
            slot = (slot == 0) ? HIST - 1 : slot - 1;
            sum += ring[ch][slot];
        end
        avg = (sum << 16) / n;
        prod = longint'(gain_r) * longint'(avg >> 16);
        if (prod > (64'sd1 <<< 40)) prod = 64'sd1 <<< 40;
        if (prod < -(64'sd1 <<< 40)) prod = -(64'sd1 <<< 40);
        part = (longint'(gain_r) * longint'(avg[15:0])) >>> 16;
        total = prod + part + longint'(offset_r);
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        return total[31:0];
    endfunction

    // one scheduler step of the scan
    function automatic out_item_t scan_step(in_item_t it);
        out_item_t r;
        logic [16:0] acc;
        r = '0;
        r.phase = scan_ph;
        case (scan_ph)
            PH_SELECT: begin
                mux_sel = scan_ch;
                settle_acc = 0;
                scan_ph = PH_SETTLE;
            end
            PH_SETTLE: begin
                acc = {1'b0, settle_acc} + it.elapsed_ticks;
                settle_acc = acc[16] ? 16'hFFFF : acc[15:0];
                if (settle_acc > settle_r) scan_ph = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                r.value_q16 = calibrated_average(scan_ch, it.adc_code);
                r.value_valid = 1;
                r.value_channel = scan_ch;
                scan_ph = PH_STOP;
            end
            default: begin
                r.stop_convert = 1;
                scan_ch = scan_ch + 1;
                scan_ph = PH_SELECT;
            end
        endcase
        r.mux_address = mux_sel;
        return r;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_GAIN:   gain_r = val;
            CFG_OFFSET: offset_r = val;
            CFG_DEPTH:  depth_r = val[4:0];
            default:    settle_r = val[15:0];
        endcase
        @(negedge aclk);
        cfg_valid <= 0;
        @(negedge aclk);
    endtask

    task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
        out_item_t p;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_data <= it;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
        p = scan_step(it);
        pending_results.push_back(typed ? typed_res : p);
        @(negedge aclk);
    endtask

    // drain before touching registers
    task automatic wait_idle();
        s_valid <= 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    // result side backpressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
        end
    end

    // result check
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item %h", $realtime, m_data);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_data.mux_address !== e.mux_address) begin
                    $display("%0t: mux_address exp %0d got %0d", $realtime,
                             e.mux_address, m_data.mux_address);
                    errors++;
                end
                if (m_data.phase !== e.phase) begin
                    $display("%0t: phase exp %0d got %0d", $realtime, e.phase, m_data.phase);
                    errors++;
                end
                if (m_data.stop_convert !== e.stop_convert) begin
                    $display("%0t: stop_convert exp %0d got %0d", $realtime,
                             e.stop_convert, m_data.stop_convert);
                    errors++;
                end
                if (m_data.value_valid !== e.value_valid) begin
                    $display("%0t: value_valid exp %0d got %0d", $realtime,
                             e.value_valid, m_data.value_valid);
                    errors++;
                end
                if (m_data.value_channel !== e.value_channel) begin
                    $display("%0t: value_channel exp %0d got %0d", $realtime,
                             e.value_channel, m_data.value_channel);
                    errors++;
                end
                if (m_data.value_q16 !== e.value_q16) begin
                    $display("%0t: value_q16 exp %h got %h", $realtime,
                             e.value_q16, m_data.value_q16);
                    errors++;
                end
            end
        end
    end

    // watchdog on stalled traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[mux_scan_moving_average_calibrate] ERROR");
            $finish;
        end
    end

    initial begin
        row_t dir_tab[$];
        in_item_t it;
        logic [31:0] g, o;
        aresetn = 0;
        s_valid = 0;
        s_data = '0;
        m_ready = 0;
        cfg_valid = 0;
        cfg_index = CFG_GAIN;
        cfg_data = '0;
        gain_r = 32'sd65536;
        offset_r = 0;
        depth_r = 10;
        settle_r = 200;
        scan_ph = PH_SELECT;
        scan_ch = 0;
        settle_acc = 0;
        mux_sel = 0;
        for (int c = 0; c < N_CH; c++) begin
            ring_wr[c] = 0;
            ring_fill[c] = 0;
        end
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: saturation both ways, depth zero and above history, settle extremes
        dir_tab = '{
            '{ROW_CFG, CFG_SETTLE, 32'd0, 1'b0, '0},
            '{ROW_CFG, CFG_DEPTH, 32'd0, 1'b0, '0},
            '{ROW_CFG, CFG_GAIN, 32'h7FFF_FFFF, 1'b0, '0},
            '{ROW_CFG, CFG_OFFSET, 32'h7FFF_FFFF, 1'b0, '0},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd0}, 1'b1, '{0, 0, 0, 0, PH_SELECT, 0}},
            '{ROW_ITEM, CFG_GAIN, {24'hABCDEF, 8'd0}, 1'b1, '{0, 0, 0, 0, PH_SETTLE, 0}},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'hFF}, 1'b1, '{0, 0, 0, 0, PH_SETTLE, 0}},
            '{ROW_ITEM, CFG_GAIN, {24'hFFFFFF, 8'd0}, 1'b1,
              '{32'h7FFF_FFFF, 0, 1, 0, PH_SAMPLE, 0}},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd0}, 1'b1, '{0, 0, 0, 1, PH_STOP, 0}},
            '{ROW_CFG, CFG_GAIN, 32'h8000_0000, 1'b0, '0},
            '{ROW_CFG, CFG_OFFSET, 32'h8000_0000, 1'b0, '0},
            '{ROW_CFG, CFG_DEPTH, 32'd31, 1'b0, '0},
            '{ROW_ITEM, CFG_GAIN, {24'h5A5A5A, 8'hA5}, 1'b1, '{0, 0, 0, 0, PH_SELECT, 1}},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd1}, 1'b1, '{0, 0, 0, 0, PH_SETTLE, 1}},
            '{ROW_ITEM, CFG_GAIN, {24'hFFFFFF, 8'd0}, 1'b1,
              '{32'h8000_0000, 1, 1, 0, PH_SAMPLE, 1}},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd0}, 1'b1, '{0, 0, 0, 1, PH_STOP, 1}},
            '{ROW_CFG, CFG_GAIN, 32'd65536, 1'b0, '0},
            '{ROW_CFG, CFG_OFFSET, 32'd0, 1'b0, '0},
            '{ROW_CFG, CFG_DEPTH, 32'd16, 1'b0, '0},
            '{ROW_CFG, CFG_SETTLE, 32'hFFFF_FFFF, 1'b0, '0},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd0}, 1'b1, '{0, 0, 0, 0, PH_SELECT, 2}},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'hFF}, 1'b1, '{0, 0, 0, 0, PH_SETTLE, 2}},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'hFF}, 1'b1, '{0, 0, 0, 0, PH_SETTLE, 2}},
            '{ROW_CFG, CFG_SETTLE, 32'd10, 1'b0, '0},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd0}, 1'b0, '0},
            '{ROW_ITEM, CFG_GAIN, {24'h123456, 8'd7}, 1'b0, '0},
            '{ROW_ITEM, CFG_GAIN, {24'h000000, 8'd0}, 1'b0, '0}
        };
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                if (i > 0 && dir_tab[i - 1].kind == ROW_ITEM) wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_item(dir_tab[i].data, dir_tab[i].has_exp, dir_tab[i].exp);
            end
        end

        // random phases, each under its own register setting; the last without idling
        for (int ph = 0; ph < 9; ph++) begin
            wait_idle();
            case ($urandom_range(0, 4))
                0: g = 32'h7FFF_FFFF;
                1: g = 32'h8000_0000;
                2: g = $urandom;
                3: g = $urandom_range(0, 200000);
                default: g = -$urandom_range(0, 200000);
            endcase
            case ($urandom_range(0, 3))
                0: o = 32'h7FFF_FFFF;
                1: o = 32'h8000_0000;
                2: o = $urandom;
                default: o = $urandom_range(0, 65536);
            endcase
            write_reg(CFG_GAIN, g);
            write_reg(CFG_OFFSET, o);
            write_reg(CFG_DEPTH, (ph == 1) ? 32'd0 : (ph == 2) ? 32'd31 : $urandom_range(0, 31));
            write_reg(CFG_SETTLE, (ph == 3) ? 32'd65535 : (ph == 4) ? 32'd0 :
                      $urandom_range(0, 700));
            idle_on = (ph < 8);
            repeat (210) begin
                it.elapsed_ticks = $urandom_range(0, 255);
                case ($urandom_range(0, 7))
                    0: it.adc_code = 24'h000000;
                    1: it.adc_code = 24'hFFFFFF;
                    default: it.adc_code = $urandom;
                endcase
                send_item(it, 1'b0, '0);
            end
        end

        s_valid <= 0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("[mux_scan_moving_average_calibrate] OK");
        else
            $display("[mux_scan_moving_average_calibrate] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
